// File: sv/multi_zone_motion_aggregator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motion aggregator checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_ZONE_MOTION_AGGREGATOR_UNIT_ASSERT_SVH
`define MULTI_ZONE_MOTION_AGGREGATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MZMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MZMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mzma_pkg.sv
// ----------------------------------------------------------------------------
// mzma_pkg
// Types, constants and slot field helpers for the motion aggregator.
// ----------------------------------------------------------------------------
package mzma_pkg;

  localparam int ZONE_SLOTS_DEF = 4;
  localparam int MASK_SLOTS     = 4;   // slots the valid mask can select

  // configuration register indexes
  localparam int          CFG_IDX_W = 3;
  localparam int          CFG_DATA_W = 36;
  localparam logic [2:0]  CFG_ENABLE = 3'd0;
  localparam logic [2:0]  CFG_MASK   = 3'd1;
  localparam logic [2:0]  CFG_IDS    = 3'd2;
  localparam logic [2:0]  CFG_PRIO   = 3'd3;
  localparam logic [2:0]  CFG_SENS   = 3'd4;

  // arithmetic widths
  localparam int W_W    = 17;             // priority weight, Q1.16
  localparam int NUM_W  = 27;             // sum of s*W over four slots
  localparam int DEN_W  = 19;             // sum of W over four slots
  localparam int QUO_W  = 17;             // divider quotient
  localparam int DVD_W  = DEN_W + QUO_W;  // divider dividend
  localparam logic [W_W-1:0] W_ONE     = 17'h10000;
  localparam logic [20:0]    DIV10_M   = 21'd1677722;  // ceil(2^24/10)
  localparam logic [7:0]     NO_ZONE   = 8'hFF;

  typedef struct packed {
    logic [3:0]  motion_bits;
    logic [31:0] timestamp;
    logic        clear_stats;
    logic [1:0]  stat_zone;
  } in_beat_t;

  typedef struct packed {
    logic        motion_detected;
    logic [2:0]  active_count;
    logic [3:0]  active_mask;
    logic [7:0]  top_zone_id;
    logic [15:0] confidence;
    logic [31:0] stat_count;
    logic [15:0] stat_average;
    logic [31:0] stat_last_time;
    logic        stat_active;
  } out_beat_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGO,
    ST_WWAIT,
    ST_SCAN,
    ST_STAT,
    ST_DGO,
    ST_DWAIT,
    ST_FIN
  } state_t;

  function automatic logic [7:0] byte_of(logic [31:0] r, logic [1:0] k);
    return r[8*k +: 8];
  endfunction

  function automatic logic [8:0] sens_of(logic [35:0] r, logic [1:0] k);
    logic [8:0] s;
    s = r[9*k +: 9];
    return (s > 9'd256) ? 9'd256 : s;
  endfunction

endpackage

// File: sv/mzma_stream_if.sv
// ----------------------------------------------------------------------------
// mzma_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ----------------------------------------------------------------------------
interface mzma_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input ready, input data);
endinterface

// File: sv/mzma_div.sv
// ----------------------------------------------------------------------------
// mzma_div
// Restoring divider, one quotient bit a cycle. The caller guarantees that the
// quotient fits in QUO_W bits, so the partial remainder starts at the top bits.
// ----------------------------------------------------------------------------
module mzma_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mzma_pkg::DVD_W-1:0]    dividend,
  input  logic [mzma_pkg::DEN_W-1:0]    divisor,
  output mzma_pkg::div_sts_t            sts
);

  localparam int DEN_W = mzma_pkg::DEN_W;
  localparam int QUO_W = mzma_pkg::QUO_W;
  localparam int DVD_W = mzma_pkg::DVD_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dsr_r, dsr_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    trial    = {rem_r, quo_r[QUO_W-1]};
    ge       = (trial >= {1'b0, dsr_r});
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      rem_nxt = dividend[DVD_W-1:QUO_W];
      quo_nxt = dividend[QUO_W-1:0];
      dsr_nxt = divisor;
      cnt_nxt = CNT_W'(QUO_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, dsr_r}) : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[QUO_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

// File: sv/multi_zone_motion_aggregator_unit.sv
// ----------------------------------------------------------------------------
// multi_zone_motion_aggregator_unit
// Masks per-zone motion, picks the most important active zone, forms a
// priority-weighted confidence and keeps per-zone detection statistics.
// ----------------------------------------------------------------------------
// One input beat is worked through a slot at a time by a small sequencer, then
// the confidence is divided out on a shared bit-serial divider (17 quotient
// bits). With N = min(ZONE_SLOTS, 4) scanned slots, an enabled beat goes
// through SCAN for each of the N slots, then STAT, DGO, DWAIT and FIN; without
// active zones it skips the divider (DGO straight to FIN), and a disabled beat
// goes from STAT to FIN. The input is ready again once the sequencer is back in
// IDLE with no weight refresh pending. The result sits in an output register,
// so the next beat is taken while it waits. A write to zone_priorities starts
// a refresh of the 1/(p+1) weight table on the same divider, during which
// in_if.ready is low. Statistics live in flip-flops and all clear together.
module multi_zone_motion_aggregator_unit #(
  parameter int ZONE_SLOTS = mzma_pkg::ZONE_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mzma_stream_if.sink                       in_if,
  mzma_stream_if.source                     out_if,
  input  logic                              cfg_we,
  input  logic [mzma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mzma_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int ACT_SLOTS = (ZONE_SLOTS < mzma_pkg::MASK_SLOTS) ?
                             ZONE_SLOTS : mzma_pkg::MASK_SLOTS;
  localparam int IDX_W  = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam int WIDX_W = (ACT_SLOTS > 1) ? $clog2(ACT_SLOTS) : 1;
  localparam logic [3:0] ACT_MASK = 4'((1 << ACT_SLOTS) - 1);
  localparam int W_W   = mzma_pkg::W_W;
  localparam int NUM_W = mzma_pkg::NUM_W;
  localparam int DEN_W = mzma_pkg::DEN_W;
  localparam int DVD_W = mzma_pkg::DVD_W;

  // configuration
  logic        en_cfg_r;
  logic [3:0]  mask_cfg_r;
  logic [31:0] ids_cfg_r;
  logic [31:0] prio_cfg_r;
  logic [35:0] sens_cfg_r;

  // sequencer
  mzma_pkg::state_t state_r, state_nxt;
  logic             wref_pend_r, wref_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             div_start;
  logic             in_acc;
  logic             in_rdy;
  logic             prio_wr;

  // working registers of one beat
  logic [IDX_W-1:0]  slot_r;
  logic [3:0]        act_r;
  logic [31:0]       ts_r;
  logic [1:0]        sel_r;
  logic              en_item_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [2:0]        count_r;
  logic [7:0]        best_r;
  logic [7:0]        top_r;
  logic [15:0]       conf_r;
  logic [31:0]       st_cnt_r;
  logic [15:0]       st_avg_r;
  logic [31:0]       st_time_r;
  logic              st_seen_r;
  mzma_pkg::out_beat_t out_data_r;

  // weight table and per-zone statistics
  logic [W_W-1:0] weight_r [ACT_SLOTS];
  logic [31:0]    cnt_st_r  [ZONE_SLOTS];
  logic [15:0]    avg_st_r  [ZONE_SLOTS];
  logic [31:0]    time_st_r [ZONE_SLOTS];
  logic           seen_st_r [ZONE_SLOTS];

  // slot datapath
  logic [1:0]        slot2;
  logic [WIDX_W-1:0] wslot;
  logic              slot_last;
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_cnt;
  logic [15:0]       rd_avg;
  logic [31:0]       rd_time;
  logic              rd_seen;
  logic              cur_act;
  logic [7:0]        cur_prio;
  logic [8:0]        cur_sens;
  logic [8:0]        prio_d;
  logic [W_W-1:0]    cur_w;
  logic [25:0]       sw_prod;
  logic [15:0]       sample;
  logic [19:0]       avg_sum;
  logic [40:0]       avg_prod;
  logic [15:0]       avg_upd;
  logic              sel_ok;

  // divider
  logic [DVD_W-1:0]   div_dvd;
  logic [DEN_W-1:0]   div_dsr;
  mzma_pkg::div_sts_t div_sts;

  assign prio_wr     = cfg_we && (cfg_index == mzma_pkg::CFG_PRIO);
  assign in_rdy      = (state_r == mzma_pkg::ST_IDLE) && !wref_pend_r && !prio_wr;
  assign in_if.ready = in_rdy;
  assign in_acc      = in_if.valid && in_rdy;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_cfg_r   <= 1'b0;
      mask_cfg_r <= '0;
      ids_cfg_r  <= '0;
      prio_cfg_r <= '0;
      sens_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mzma_pkg::CFG_ENABLE: en_cfg_r   <= cfg_wdata[0];
        mzma_pkg::CFG_MASK:   mask_cfg_r <= cfg_wdata[3:0];
        mzma_pkg::CFG_IDS:    ids_cfg_r  <= cfg_wdata[31:0];
        mzma_pkg::CFG_PRIO:   prio_cfg_r <= cfg_wdata[31:0];
        mzma_pkg::CFG_SENS:   sens_cfg_r <= cfg_wdata[35:0];
        default: ;
      endcase
    end
  end

  // ---- slot datapath ----
  assign slot2     = 2'(slot_r);
  assign wslot     = slot_r[WIDX_W-1:0];
  assign slot_last = (slot_r == IDX_W'(ACT_SLOTS - 1));
  assign rd_idx    = (state_r == mzma_pkg::ST_STAT) ? IDX_W'(sel_r) : slot_r;
  assign rd_cnt    = cnt_st_r[rd_idx];
  assign rd_avg    = avg_st_r[rd_idx];
  assign rd_time   = time_st_r[rd_idx];
  assign rd_seen   = seen_st_r[rd_idx];
  assign sel_ok    = (int'(sel_r) < ZONE_SLOTS);

  assign cur_act  = act_r[slot2];
  assign cur_prio = mzma_pkg::byte_of(prio_cfg_r, slot2);
  assign cur_sens = mzma_pkg::sens_of(sens_cfg_r, slot2);
  assign prio_d   = {1'b0, cur_prio} + 9'd1;
  assign cur_w    = weight_r[wslot];
  assign sw_prod  = 26'(cur_sens) * 26'(cur_w);

  assign sample   = (cur_sens == 9'd256) ? 16'hFFFF : {cur_sens[7:0], 8'h00};
  // 9*avg + sample + 5, then divide by ten through the reciprocal
  assign avg_sum  = 20'({rd_avg, 3'b000}) + 20'(rd_avg) + 20'(sample) + 20'd5;
  assign avg_prod = 41'(avg_sum) * 41'(mzma_pkg::DIV10_M);
  assign avg_upd  = (rd_cnt == '0) ? sample : avg_prod[39:24];

  // shared divider: weight refresh or confidence
  always_comb begin
    if (state_r == mzma_pkg::ST_DGO) begin
      div_dvd = DVD_W'({num_r, 8'h00}) + DVD_W'(den_r >> 1);
      div_dsr = den_r;
    end else begin
      div_dvd = DVD_W'(mzma_pkg::W_ONE) + DVD_W'(prio_d >> 1);
      div_dsr = DEN_W'(prio_d);
    end
  end

  mzma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .sts      (div_sts)
  );

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mzma_pkg::ST_IDLE;
      wref_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wref_pend_r <= wref_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wref_pend_nxt = wref_pend_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    div_start     = 1'b0;
    case (state_r)
      mzma_pkg::ST_IDLE: begin
        if (wref_pend_r) begin
          wref_pend_nxt = 1'b0;
          state_nxt     = mzma_pkg::ST_WGO;
        end else if (in_acc) begin
          state_nxt = en_cfg_r ? mzma_pkg::ST_SCAN : mzma_pkg::ST_STAT;
        end
      end
      mzma_pkg::ST_WGO: begin
        div_start = 1'b1;
        state_nxt = mzma_pkg::ST_WWAIT;
      end
      mzma_pkg::ST_WWAIT: begin
        if (div_sts.done) begin
          state_nxt = (wslot == WIDX_W'(ACT_SLOTS - 1)) ? mzma_pkg::ST_IDLE
                                                         : mzma_pkg::ST_WGO;
        end
      end
      mzma_pkg::ST_SCAN: begin
        if (slot_last) state_nxt = mzma_pkg::ST_STAT;
      end
      mzma_pkg::ST_STAT: begin
        state_nxt = en_item_r ? mzma_pkg::ST_DGO : mzma_pkg::ST_FIN;
      end
      mzma_pkg::ST_DGO: begin
        if (den_r == '0) begin
          state_nxt = mzma_pkg::ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = mzma_pkg::ST_DWAIT;
        end
      end
      mzma_pkg::ST_DWAIT: begin
        if (div_sts.done) state_nxt = mzma_pkg::ST_FIN;
      end
      mzma_pkg::ST_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = mzma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mzma_pkg::ST_IDLE;
    endcase
    if (prio_wr) wref_pend_nxt = 1'b1;
  end

  // ---- beat working registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      mzma_pkg::ST_IDLE: begin
        slot_r <= '0;
        if (in_acc) begin
          act_r     <= en_cfg_r ? (in_if.data.motion_bits & mask_cfg_r & ACT_MASK) : 4'h0;
          ts_r      <= in_if.data.timestamp;
          sel_r     <= in_if.data.stat_zone;
          en_item_r <= en_cfg_r;
          num_r     <= '0;
          den_r     <= '0;
          count_r   <= '0;
          best_r    <= mzma_pkg::NO_ZONE;
          top_r     <= en_cfg_r ? mzma_pkg::NO_ZONE : 8'h00;
          conf_r    <= '0;
        end
      end
      mzma_pkg::ST_WWAIT: begin
        if (div_sts.done) slot_r <= slot_r + 1'b1;
      end
      mzma_pkg::ST_SCAN: begin
        slot_r <= slot_r + 1'b1;
        if (cur_act) begin
          num_r   <= num_r + NUM_W'(sw_prod);
          den_r   <= den_r + DEN_W'(cur_w);
          count_r <= count_r + 3'd1;
          // strict compare keeps the lower slot on a tie; 255 never wins
          if (cur_prio < best_r) begin
            best_r <= cur_prio;
            top_r  <= mzma_pkg::byte_of(ids_cfg_r, slot2);
          end
        end
      end
      mzma_pkg::ST_STAT: begin
        if (en_item_r && sel_ok) begin
          st_cnt_r  <= rd_cnt;
          st_avg_r  <= rd_avg;
          st_time_r <= rd_time;
          st_seen_r <= rd_seen;
        end else begin
          st_cnt_r  <= '0;
          st_avg_r  <= '0;
          st_time_r <= '0;
          st_seen_r <= 1'b0;
        end
      end
      mzma_pkg::ST_DWAIT: begin
        if (div_sts.done) begin
          conf_r <= (div_sts.quotient[16]) ? 16'hFFFF : div_sts.quotient[15:0];
        end
      end
      mzma_pkg::ST_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_data_r.motion_detected <= (count_r != '0);
          out_data_r.active_count    <= count_r;
          out_data_r.active_mask     <= act_r;
          out_data_r.top_zone_id     <= top_r;
          out_data_r.confidence      <= conf_r;
          out_data_r.stat_count      <= st_cnt_r;
          out_data_r.stat_average    <= st_avg_r;
          out_data_r.stat_last_time  <= st_time_r;
          out_data_r.stat_active     <= st_seen_r;
        end
      end
      default: ;
    endcase
  end

  // weights reset to those of priority zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ACT_SLOTS; k++) weight_r[k] <= mzma_pkg::W_ONE;
    end else if (state_r == mzma_pkg::ST_WWAIT && div_sts.done) begin
      weight_r[wslot] <= div_sts.quotient;
    end
  end

  // zone statistics; a clear lands before any update of the same beat
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_if.data.clear_stats)) begin
      for (int k = 0; k < ZONE_SLOTS; k++) begin
        cnt_st_r[k]  <= '0;
        avg_st_r[k]  <= '0;
        time_st_r[k] <= '0;
        seen_st_r[k] <= 1'b0;
      end
    end else if (state_r == mzma_pkg::ST_SCAN && cur_act) begin
      if (rd_cnt != 32'hFFFF_FFFF) cnt_st_r[slot_r] <= rd_cnt + 32'd1;
      avg_st_r[slot_r]  <= avg_upd;
      time_st_r[slot_r] <= ts_r;
      seen_st_r[slot_r] <= 1'b1;
    end
  end

endmodule

// File: sv/mzma_checker.sv
// ----------------------------------------------------------------------------
// mzma_checker
// Port-level checks on the motion aggregator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_zone_motion_aggregator_unit_assert.svh"

module mzma_checker (
  input logic              clk,
  input logic              rst_n,
  mzma_stream_if.sink      in_if,
  mzma_stream_if.source    out_if
);

  // detected flag, count and mask must agree on every result beat, and confidence is zero without active zones
  `MZMA_ASSERT_NOW(a_count_mask, out_if.valid, out_if.data.active_count == 3'($countones(out_if.data.active_mask)), "active_count disagrees with active_mask")
  `MZMA_ASSERT_NOW(a_detect, out_if.valid, out_if.data.motion_detected == (out_if.data.active_mask != 4'h0), "motion_detected disagrees with active_mask")
  `MZMA_ASSERT_NOW(a_idle_conf, out_if.valid && (out_if.data.active_mask == 4'h0), out_if.data.confidence == 16'h0000, "confidence without active zones")
  // one beat at a time
  `MZMA_ASSERT_NEXT(a_one_beat, in_if.valid && in_if.ready, !in_if.ready, "input taken again straight after a beat")

endmodule

bind multi_zone_motion_aggregator_unit mzma_checker u_mzma_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
